/* hw/rtl/rank_merge_placer_defines.svh */
// Assertion macros used by the search sequencer of the rank merge placer.
`ifndef RANK_MERGE_PLACER_DEFINES_SVH
`define RANK_MERGE_PLACER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RMP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RMP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/rmp_pkg.sv */
// Types and constants of the rank merge placer.
`timescale 1ns / 1ps
package rmp_pkg;

   localparam int COUNT_W = 9;
   localparam int SLOT_W  = 8;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 9;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

   typedef enum logic [1:0] {
      OP_WRITE_X = 2'd0,
      OP_WRITE_Y = 2'd1,
      OP_PLACE   = 2'd2
   } op_type;

   typedef enum logic {
      REG_X_COUNT = 1'b0,
      REG_Y_COUNT = 1'b1
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic [1:0]              op;
      logic                    side;
      logic [SLOT_W-1:0]       slot;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] placed_value;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] x_count;
      logic [COUNT_W-1:0] y_count;
   } counts_type;

endpackage

/* hw/rtl/rmp_ram.sv */
// Single-port-write, registered-read memory holding one sorted array.
`timescale 1ns / 1ps
module rmp_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rmp_csr.sv */
// Count registers behind the APB-style configuration port.
`timescale 1ns / 1ps
module rmp_csr
   import rmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output counts_type  counts
);

   logic [COUNT_W-1:0] x_count_ff;
   logic [COUNT_W-1:0] y_count_ff;
   logic               wr_beat;

   assign wr_beat = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= COUNT_RESET;
         y_count_ff <= COUNT_RESET;
      end else if (wr_beat) begin
         if (paddr[2] == REG_X_COUNT) begin
            x_count_ff <= pwdata[COUNT_W-1:0];
         end else begin
            y_count_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_X_COUNT: prdata[COUNT_W-1:0] = x_count_ff;
         REG_Y_COUNT: prdata[COUNT_W-1:0] = y_count_ff;
         default:     prdata = '0;
      endcase
   end

   assign counts.x_count = x_count_ff;
   assign counts.y_count = y_count_ff;

endmodule

/* hw/rtl/rmp_search.sv */
// Command decode and binary-search sequencer over the two array memories.
`timescale 1ns / 1ps
module rmp_search
   import rmp_pkg::*;
#(
   parameter int DEPTH       = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  req_type                  req,
   input  counts_type               counts,
   output logic                     busy,
   output logic                     wr_x_en,
   output logic                     wr_y_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [VALUE_WIDTH-1:0]   wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [VALUE_WIDTH-1:0]   x_rdata,
   input  logic [VALUE_WIDTH-1:0]   y_rdata,
   output logic                     rsp_strobe,
   output rsp_type                  rsp
);

   `include "rank_merge_placer_defines.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type            state_ff, state_in;
   logic                 side_ff, side_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        mid_ff, mid_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CW-1:0]        x_eff, y_eff, own_eff, slot_ext;
   logic [CW-1:0]        lo_nx, hi_nx, pos_sum;
   logic [VALUE_WIDTH-1:0] own_rdata, other_rdata, cur_val;
   logic                 slot_in_store, counted;

   assign x_eff = (CW'(counts.x_count) > DEPTH_C) ? DEPTH_C : CW'(counts.x_count);
   assign y_eff = (CW'(counts.y_count) > DEPTH_C) ? DEPTH_C : CW'(counts.y_count);
   assign own_eff = req.side ? y_eff : x_eff;
   assign slot_ext = CW'(req.slot);
   assign slot_in_store = slot_ext < DEPTH_C;

   assign own_rdata   = side_ff ? y_rdata : x_rdata;
   assign other_rdata = side_ff ? x_rdata : y_rdata;

   assign wr_addr = AW'(req.slot);
   assign wr_data = VALUE_WIDTH'(req.value);
   assign busy    = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      side_ff <= side_in;
      slot_ff <= slot_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      slot_in      = slot_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_x_en      = 1'b0;
      wr_y_en      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = AW'(req.slot);
      lo_nx        = lo_ff;
      hi_nx        = hi_ff;
      cur_val      = val_ff;
      counted      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req.op == OP_WRITE_X) begin
                  wr_x_en = slot_in_store;
               end else if (req.op == OP_WRITE_Y) begin
                  wr_y_en = slot_in_store;
               end else if (req.op == OP_PLACE && slot_ext < own_eff) begin
                  rd_en    = 1'b1;
                  side_in  = req.side;
                  slot_in  = req.slot;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cur_val = own_rdata;
            val_in  = own_rdata;
            lo_nx   = '0;
            hi_nx   = side_ff ? x_eff : y_eff;
         end
         ST_SEARCH: begin
            counted = side_ff ? ($signed(other_rdata) <= $signed(val_ff))
                              : ($signed(other_rdata) <  $signed(val_ff));
            lo_nx   = counted ? mid_ff + CW'(1) : lo_ff;
            hi_nx   = counted ? hi_ff : mid_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pos_sum = CW'(slot_ff) + lo_nx;
      if (state_ff == ST_FETCH || state_ff == ST_SEARCH) begin
         lo_in  = lo_nx;
         hi_in  = hi_nx;
         mid_in = lo_nx + ((hi_nx - lo_nx) >> 1);
         if (lo_nx < hi_nx) begin
            rd_en    = 1'b1;
            rd_addr  = mid_in[AW-1:0];
            state_in = ST_SEARCH;
         end else begin
            rsp_valid_in        = 1'b1;
            rsp_in.position     = pos_sum[POS_W-1:0];
            rsp_in.placed_value = DATA_W'(cur_val);
            state_in            = ST_IDLE;
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp        = rsp_ff;

   `RMP_ASSERT(a_search_window, (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff), "Empty search window while searching.")
   `RMP_ASSERT(a_probe_in_window, (state_ff == ST_SEARCH) |-> (mid_ff >= lo_ff && mid_ff < hi_ff), "Probe outside the search window.")
   `RMP_ASSERT(a_no_write_busy, busy |-> !(wr_x_en || wr_y_en), "Array write during a search.")
   `RMP_ASSERT(a_beat_after_search, rsp_valid_ff |-> $past(state_ff == ST_FETCH || state_ff == ST_SEARCH), "Result beat without a finished search.")
   `RMP_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "Not idle after reset.")

endmodule

/* hw/rtl/rank_merge_placer.sv */
// Top level of the rank merge placer: two array memories, count registers, search sequencer.
`timescale 1ns / 1ps
// A write command is done once it is accepted and gives no result; busy stays low.
// A place command reads its own element and then binary-searches the other
// array with one memory read per probe, so it keeps busy high through the
// fetch state and then one search state per probe; the probes number at most
// ceil(log2(n + 1)) for n valid entries in the other array. The single read
// port of each array memory allows only one probe at a time. The result beat
// appears in the same cycle that busy falls, for exactly one cycle, and cannot be
// held off; a new command may be issued in that same cycle. Commands naming an
// element beyond its array's count, and unused op codes, give no result.
module rank_merge_placer
   import rmp_pkg::*;
#(
   parameter int DEPTH       = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(DEPTH);

   counts_type             counts;
   logic                   wr_x_en, wr_y_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data, x_rdata, y_rdata;

   rmp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .counts  (counts)
   );

   rmp_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_WIDTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_x_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (x_rdata)
   );

   rmp_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_WIDTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_y_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (y_rdata)
   );

   rmp_search #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .counts     (counts),
      .busy       (busy),
      .wr_x_en    (wr_x_en),
      .wr_y_en    (wr_y_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .x_rdata    (x_rdata),
      .y_rdata    (y_rdata),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

/* tb/sv/tb_rank_merge_placer.sv */
// Self-checking testbench for the rank merge placer: command stimulus, CSR setup, result scoreboard.
`timescale 1ns / 1ps
module tb_rank_merge_placer;
   import rmp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int STORE_DEPTH = 256;
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEM_TARGET = 500;
   localparam int WIDE_SPREAD = 1 << 25;

   class merge_place_scoreboard;
      logic signed [DATA_W-1:0] x_mem [STORE_DEPTH];
      logic signed [DATA_W-1:0] y_mem [STORE_DEPTH];
      logic [COUNT_W-1:0] x_count = COUNT_RESET;
      logic [COUNT_W-1:0] y_count = COUNT_RESET;
      rsp_type expected_places [$];
      int errors = 0;

      function void set_count(reg_idx_type idx, logic [COUNT_W-1:0] v);
         if (idx == REG_X_COUNT) begin
            x_count = v;
         end else begin
            y_count = v;
         end
      endfunction

      function int pending();
         return expected_places.size();
      endfunction

      function int usable(logic [COUNT_W-1:0] c);
         return (c > STORE_DEPTH) ? STORE_DEPTH : int'(c);
      endfunction

      // Lower bound (upper bound when or_equal is set) over the first n entries of the other array.
      function logic [POS_W-1:0] rank_in(logic signed [DATA_W-1:0] key, bit search_x, int n,
                                         bit or_equal);
         int lo;
         int hi;
         int mid;
         logic signed [DATA_W-1:0] probe;
         bit below;
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            probe = search_x ? x_mem[mid] : y_mem[mid];
            below = or_equal ? (probe <= key) : (probe < key);
            if (below) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return POS_W'(lo);
      endfunction

      function void note_command(req_type r);
         rsp_type want;
         int slot_i;
         slot_i = int'(r.slot);
         case (r.op)
            OP_WRITE_X: x_mem[r.slot] = r.value;
            OP_WRITE_Y: y_mem[r.slot] = r.value;
            OP_PLACE: begin
               if (!r.side && slot_i < usable(x_count)) begin
                  want.placed_value = x_mem[r.slot];
                  want.position = POS_W'(slot_i)
                     + rank_in(want.placed_value, 1'b0, usable(y_count), 1'b0);
                  expected_places.push_back(want);
               end else if (r.side && slot_i < usable(y_count)) begin
                  want.placed_value = y_mem[r.slot];
                  want.position = POS_W'(slot_i)
                     + rank_in(want.placed_value, 1'b1, usable(x_count), 1'b1);
                  expected_places.push_back(want);
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_places.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: position %0d value %0d",
                                      got.position, got.placed_value));
            return;
         end
         want = expected_places.pop_front();
         if (got.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, want.position));
         if (got.placed_value !== want.placed_value)
            report_mismatch($sformatf("placed_value %0d, expected %0d",
                                      got.placed_value, want.placed_value));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   req_type     req_data;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   merge_place_scoreboard sb = new;
   int work_items = 0;

   rank_merge_placer dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Every result beat is checked against the oldest expected placement.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_data);
   end

   function automatic req_type make_cmd(logic [1:0] op, logic side, int slot,
                                        logic signed [DATA_W-1:0] v);
      req_type c;
      c.op = op;
      c.side = side;
      c.slot = SLOT_W'(slot);
      c.value = v;
      return c;
   endfunction

   task automatic send(input req_type r);
      if (!(work_items >= 200 && work_items < 350) && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_command(r);
      if (r.op != OP_UNUSED) work_items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [COUNT_W-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(idx) << 2;
      pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_count(idx, v);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Writes entries 0..n-1 in ascending order; a spread of 1 gives many ties.
   task automatic load_array(logic [1:0] op, int n, int spread);
      longint acc;
      int i;
      if (spread > 1000) begin
         acc = longint'(VAL_MIN) + $urandom_range(0, spread);
      end else begin
         acc = longint'($signed($urandom)) >>> 1;
      end
      for (i = 0; i < n; i++) begin
         send(make_cmd(op, 1'($urandom), i, DATA_W'(acc)));
         acc += $urandom_range(0, spread);
         if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
      end
   endtask

   task automatic random_phase();
      int nx;
      int ny;
      int spread;
      int n_cmds;
      int i;
      int roll;
      int own;
      logic side;
      case ($urandom_range(0, 9))
         0: begin
            nx = STORE_DEPTH;
            ny = $urandom_range(1, STORE_DEPTH);
         end
         1: begin
            nx = 1;
            ny = 1;
         end
         2: begin
            nx = $urandom_range(1, 16);
            ny = STORE_DEPTH;
         end
         default: begin
            nx = $urandom_range(1, 16);
            ny = $urandom_range(1, 16);
         end
      endcase
      case ($urandom_range(0, 2))
         0: spread = 1;
         1: spread = 1000;
         default: spread = WIDE_SPREAD;
      endcase
      drain();
      csr_write(REG_X_COUNT, COUNT_W'(nx));
      csr_write(REG_Y_COUNT, COUNT_W'(ny));
      load_array(OP_WRITE_X, nx, spread);
      load_array(OP_WRITE_Y, ny, spread);
      n_cmds = $urandom_range(10, 40);
      for (i = 0; i < n_cmds; i++) begin
         roll = $urandom_range(0, 99);
         side = 1'($urandom);
         own = side ? ny : nx;
         if (roll < 80) begin
            send(make_cmd(OP_PLACE, side, $urandom_range(0, own - 1), $urandom));
         end else if (roll < 88) begin
            send(make_cmd(OP_PLACE, side,
                          (own < STORE_DEPTH) ? $urandom_range(own, 255) : $urandom_range(0, 255),
                          $urandom));
         end else if (roll < 94) begin
            send(make_cmd(OP_UNUSED, side, $urandom_range(0, 255), $urandom));
         end else begin
            send(make_cmd(side ? OP_WRITE_Y : OP_WRITE_X, 1'($urandom),
                          $urandom_range(0, 255), $urandom));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset counts of one entry each: ties, extremes and an unused op.
      send(make_cmd(OP_WRITE_X, 1'b0, 0, 32'sd7));
      send(make_cmd(OP_WRITE_Y, 1'b1, 0, 32'sd7));
      send(make_cmd(OP_PLACE, 1'b0, 0, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '1));
      send(make_cmd(OP_UNUSED, 1'b1, 255, $urandom));
      send(make_cmd(OP_WRITE_X, 1'b0, 0, VAL_MIN));
      send(make_cmd(OP_WRITE_Y, 1'b0, 0, VAL_MAX));
      send(make_cmd(OP_PLACE, 1'b0, 0, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '0));
      send(make_cmd(OP_WRITE_X, 1'b1, 0, VAL_MAX));
      send(make_cmd(OP_WRITE_Y, 1'b1, 0, VAL_MIN));
      send(make_cmd(OP_PLACE, 1'b0, 0, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '0));

      // Fill both arrays completely so that no later search meets an unwritten entry.
      drain();
      csr_write(REG_X_COUNT, COUNT_W'(STORE_DEPTH));
      csr_write(REG_Y_COUNT, COUNT_W'(STORE_DEPTH));
      load_array(OP_WRITE_X, STORE_DEPTH, WIDE_SPREAD);
      load_array(OP_WRITE_Y, STORE_DEPTH, WIDE_SPREAD);
      send(make_cmd(OP_WRITE_X, 1'b0, 0, VAL_MIN));
      send(make_cmd(OP_WRITE_Y, 1'b0, 255, VAL_MAX));
      send(make_cmd(OP_PLACE, 1'b0, 0, '0));
      send(make_cmd(OP_PLACE, 1'b0, 255, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '0));
      send(make_cmd(OP_PLACE, 1'b1, 255, '0));

      // Counts above the store depth behave as the full depth.
      drain();
      csr_write(REG_X_COUNT, 9'd511);
      csr_write(REG_Y_COUNT, 9'd300);
      send(make_cmd(OP_PLACE, 1'b0, 255, '0));
      send(make_cmd(OP_PLACE, 1'b1, 255, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '0));

      // An empty other array gives a rank of zero; an empty own array gives no beat.
      drain();
      csr_write(REG_X_COUNT, 9'd0);
      csr_write(REG_Y_COUNT, COUNT_W'(STORE_DEPTH));
      send(make_cmd(OP_PLACE, 1'b0, 0, '0));
      send(make_cmd(OP_PLACE, 1'b1, 5, '0));
      send(make_cmd(OP_PLACE, 1'b1, 255, '0));
      drain();
      csr_write(REG_X_COUNT, COUNT_W'(STORE_DEPTH));
      csr_write(REG_Y_COUNT, 9'd0);
      send(make_cmd(OP_PLACE, 1'b0, 100, '0));
      send(make_cmd(OP_PLACE, 1'b1, 0, '0));

      do random_phase(); while (work_items < ITEM_TARGET);
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rmp_pkg.sv
hw/rtl/rmp_ram.sv
hw/rtl/rmp_csr.sv
hw/rtl/rmp_search.sv
hw/rtl/rank_merge_placer.sv
tb/sv/tb_rank_merge_placer.sv
